/* rtl/core/kdp_pkg.sv */
// Package of the Kdp slope core: sizes, regression tables, shared types.
`default_nettype none
package kdp_pkg;

    // Window and ray sizes.
    localparam int W         = 17;
    localparam int HALF      = W / 2;
    localparam int MAX_GATES = 4096;
    localparam int GATE_W    = 12;
    localparam int GSEEN_W   = GATE_W + 1;
    localparam int CNT_W     = $clog2(W + 1);
    localparam int K_W       = $clog2(W);
    localparam int SAMPLE_W  = 16;
    localparam int SPACE_W   = 11;

    // Arithmetic widths, sized for the largest window.
    localparam int SIY_W = 32;
    localparam int SY_W  = 24;
    localparam int TAB_W = 24;
    localparam int P_W   = 40;
    localparam int A_W   = 48;
    localparam int MAG_W = A_W;
    localparam int B_W   = 40;
    localparam int Q_W   = 17;

    typedef logic [TAB_W-1:0] t_tab [0:W];

    // Sum of the x indices for a fit over n samples.
    function automatic t_tab make_si_tab();
        t_tab t;
        for (int n = 0; n <= W; n++) begin
            t[n] = TAB_W'(n * (n - 1) / 2);
        end
        return t;
    endfunction

    // Regression denominator n*sum(i*i) - sum(i)^2 for n samples.
    function automatic t_tab make_den_tab();
        t_tab t;
        for (int n = 0; n <= W; n++) begin
            t[n] = TAB_W'(n * n * (n * n - 1) / 12);
        end
        return t;
    endfunction

    localparam t_tab SI_TAB  = make_si_tab();
    localparam t_tab DEN_TAB = make_den_tab();

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_MUL,
        S_NUM,
        S_PREP,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [B_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic           done;
        logic           ovf;
        logic [Q_W-1:0] quo;
    } t_div_rsp;

endpackage
`default_nettype wire

/* rtl/core/kdp_cell.sv */
// One sample cell of the window chain.
`default_nettype none
module kdp_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_take_nbr,
    input  wire logic                          i_take_x,
    input  wire logic [kdp_pkg::SAMPLE_W-1:0]  i_nbr,
    input  wire logic [kdp_pkg::SAMPLE_W-1:0]  i_x,
    output logic      [kdp_pkg::SAMPLE_W-1:0]  o_q
);
    import kdp_pkg::*;

    logic [SAMPLE_W-1:0] r_q;

    // The cell either takes its neighbour's sample, a new sample, or holds.
    always_ff @(posedge i_clk) begin
        if (i_take_nbr) begin
            r_q <= i_nbr;
        end else if (i_take_x) begin
            r_q <= i_x;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

/* rtl/core/kdp_div.sv */
// Restoring divider, one quotient bit per cycle, with overflow detection.
`default_nettype none
module kdp_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire kdp_pkg::t_div_req i_req,
    output kdp_pkg::t_div_rsp      o_rsp
);
    import kdp_pkg::*;

    localparam int SH_W  = B_W + Q_W - 1;
    localparam int CMP_W = B_W + Q_W + 1;

    logic                  r_busy;
    logic [$clog2(Q_W):0]  r_step;
    logic [MAG_W-1:0]      r_rem;
    logic [SH_W-1:0]       r_dsh;
    logic [Q_W-1:0]        r_quo;
    logic                  r_done;
    logic                  r_ovf;
    logic                  w_fits;
    logic                  w_ge;

    // A quotient that needs more than Q_W bits is reported as overflow.
    assign w_fits = CMP_W'(i_req.mag) < (CMP_W'(i_req.den) << Q_W);
    assign w_ge   = CMP_W'(r_rem) >= CMP_W'(r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_ovf <= !w_fits;
                r_quo <= '0;
                r_rem <= i_req.mag;
                r_dsh <= SH_W'(i_req.den) << (Q_W - 1);
                r_step <= '0;
                r_busy <= w_fits;
                r_done <= !w_fits;
            end else if (r_busy) begin
                // One compare and subtract per quotient bit.
                if (w_ge) begin
                    r_rem <= r_rem - MAG_W'(r_dsh);
                end
                r_quo  <= {r_quo[Q_W-2:0], w_ge};
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step + 1'b1;
                if (r_step == ($clog2(Q_W)+1)'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quo  = r_quo;
endmodule
`default_nettype wire

/* rtl/core/kdp_sliding_regression_slope_core.sv */
// Top level of the sliding least-squares Kdp slope core.
`default_nettype none
// A gate that produces a fitted slope walks the window chain of 17 cells,
// then forms the products, the numerator and the divider set-up in turn,
// and runs the bit-serial divider, unless the window is not yet full and the
// numerator is not positive, which gives a zero slope. The core takes no new
// sample until the slope of that gate has been handed out. At the last gate
// of a ray the core hands out the pending gates, one per cycle while the
// output is not stalled, repeating the last slope, or zero if fewer than 17
// gates came in.
module kdp_sliding_regression_slope_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] phase_sample
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata,   // [15:0] kdp_value, [27:16] gate_index
    output logic             o_m_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_data
);
    import kdp_pkg::*;

    t_state r_state, n_state;

    logic [SPACE_W-1:0]   r_space;
    logic [GSEEN_W-1:0]   r_gates;
    logic [GSEEN_W-1:0]   r_next_out;
    logic [SAMPLE_W-1:0]  r_prev;
    logic [SAMPLE_W-1:0]  r_x;
    logic                 r_last;
    logic                 r_full;
    logic                 r_clamp;
    logic [CNT_W-1:0]     r_cnt;
    logic [K_W-1:0]       r_k;
    logic signed [SIY_W-1:0] r_siy;
    logic signed [SY_W-1:0]  r_sy;
    logic signed [P_W-1:0]   r_p1;
    logic signed [P_W-1:0]   r_p2;
    logic [B_W-1:0]          r_sd;
    logic signed [P_W-1:0]   r_num;
    logic                 r_neg;
    logic                 r_has_fit;
    logic [SAMPLE_W-1:0]  r_fit_val;
    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_out_kdp;
    logic [GATE_W-1:0]    r_out_gate;
    logic                 r_out_last;

    logic                 w_accept;
    logic                 w_slot;
    logic                 w_rot;
    logic                 w_shift;
    logic [GSEEN_W-1:0]   w_n;
    logic                 w_in_fit;
    logic                 w_in_last;
    logic [SAMPLE_W-1:0]  w_cells [0:W-1];
    logic signed [A_W-1:0] w_a;
    logic [SAMPLE_W-1:0]  w_div_val;
    logic [SAMPLE_W-1:0]  w_fill;
    logic [SPACE_W-1:0]   w_space;
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_slot      = !r_out_valid || i_m_tready;
    assign w_n         = r_gates;
    assign w_in_last   = i_s_tlast || (w_n >= GSEEN_W'(MAX_GATES - 1));
    assign w_in_fit    = (w_n >= GSEEN_W'(W)) ||
                         ((w_n >= GSEEN_W'(HALF)) && (w_n < GSEEN_W'(2 * HALF)));
    assign w_rot       = (r_state == S_WALK);
    assign w_shift     = (r_state == S_MUL) && r_full;
    assign w_space     = (r_space == '0) ? SPACE_W'(1) : r_space;

    // Window chain: fills cell by cell while the window fills, rotates during the walk, shifts in a sample when full.
    for (genvar g = 0; g < W; g++) begin : g_cell
        logic [SAMPLE_W-1:0] w_nbr;
        if (g == W - 1) begin : g_end
            assign w_nbr = w_rot ? w_cells[0] : r_x;
        end else begin : g_mid
            assign w_nbr = w_cells[g + 1];
        end
        kdp_cell u_cell (
            .i_clk      (i_clk),
            .i_take_nbr (w_rot || w_shift),
            .i_take_x   (w_accept && (w_n == GSEEN_W'(g))),
            .i_nbr      (w_nbr),
            .i_x        (i_s_tdata),
            .o_q        (w_cells[g])
        );
    end

    // Divider set-up: rounded numerator 1000*N + s*D over 2*s*D.
    assign w_a = A_W'(r_num) * A_W'(1000) + A_W'(signed'({1'b0, r_sd}));
    assign w_div_req.start = (r_state == S_PREP) && !(r_clamp && (r_num <= 0));
    assign w_div_req.mag   = w_a[A_W-1] ? MAG_W'(-w_a) : MAG_W'(w_a);
    assign w_div_req.den   = r_sd << 1;

    kdp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Saturate the signed quotient to the 16-bit result.
    always_comb begin
        if (!r_neg) begin
            if (w_div_rsp.ovf || (w_div_rsp.quo > Q_W'(32767))) begin
                w_div_val = 16'h7FFF;
            end else begin
                w_div_val = w_div_rsp.quo[SAMPLE_W-1:0];
            end
        end else begin
            if (w_div_rsp.ovf || (w_div_rsp.quo > Q_W'(32768))) begin
                w_div_val = 16'h8000;
            end else begin
                w_div_val = SAMPLE_W'(-w_div_rsp.quo);
            end
        end
    end

    assign w_fill = (r_gates >= GSEEN_W'(W)) ? r_prev : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_fit ? S_WALK : (w_in_last ? S_EMIT : S_IDLE);
                end
            end
            S_WALK: begin
                if (r_k == K_W'(W - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_NUM;
            S_NUM:  n_state = S_PREP;
            S_PREP: n_state = w_div_req.start ? S_DIV : S_EMIT;
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_has_fit && !(r_last && (r_next_out < r_gates))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ray control state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space     <= SPACE_W'(150);
            r_gates     <= '0;
            r_next_out  <= '0;
            r_prev      <= '0;
            r_has_fit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_space <= i_cfg_data;
            end
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_gates <= w_n + 1'b1;
            end
            if (r_state == S_PREP && !w_div_req.start) begin
                r_has_fit <= 1'b1;
                r_fit_val <= '0;
            end
            if (r_state == S_DIV && w_div_rsp.done) begin
                r_has_fit <= 1'b1;
                r_fit_val <= w_div_val;
            end
            if (r_state == S_EMIT) begin
                if (r_has_fit) begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_kdp   <= r_fit_val;
                        r_out_gate  <= r_next_out[GATE_W-1:0];
                        r_out_last  <= r_last && (r_next_out + 1'b1 == r_gates);
                        r_prev      <= r_fit_val;
                        r_has_fit   <= 1'b0;
                        r_next_out  <= r_next_out + 1'b1;
                    end
                end else if (r_last && (r_next_out < r_gates)) begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_kdp   <= w_fill;
                        r_out_gate  <= r_next_out[GATE_W-1:0];
                        r_out_last  <= (r_next_out + 1'b1 == r_gates);
                        r_next_out  <= r_next_out + 1'b1;
                    end
                end else if (r_last) begin
                    // End of ray: counters and the held slope start afresh.
                    r_gates    <= '0;
                    r_next_out <= '0;
                    r_prev     <= '0;
                end
            end
        end
    end

    // Datapath: latch the request, walk the chain, form the numerator.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x     <= i_s_tdata;
            r_last  <= w_in_last;
            r_full  <= (w_n >= GSEEN_W'(W));
            r_clamp <= (w_n < GSEEN_W'(W));
            r_cnt   <= (w_n >= GSEEN_W'(W)) ? CNT_W'(W) : CNT_W'(w_n + 1'b1);
            r_k     <= '0;
            r_siy   <= '0;
            r_sy    <= '0;
        end
        if (r_state == S_WALK) begin
            r_k <= r_k + 1'b1;
            if (CNT_W'(r_k) < r_cnt) begin
                r_siy <= r_siy + SIY_W'(signed'({1'b0, r_k})) * SIY_W'(signed'(w_cells[0]));
                r_sy  <= r_sy + SY_W'(signed'(w_cells[0]));
            end
        end
        if (r_state == S_MUL) begin
            r_p1 <= P_W'(signed'({1'b0, r_cnt})) * P_W'(r_siy);
            r_p2 <= P_W'(signed'({1'b0, SI_TAB[r_cnt]})) * P_W'(r_sy);
            r_sd <= B_W'(w_space) * B_W'(DEN_TAB[r_cnt]);
        end
        if (r_state == S_NUM) begin
            r_num <= r_p1 - r_p2;
        end
        if (r_state == S_PREP) begin
            r_neg <= w_a[A_W-1];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_gate, r_out_kdp};
    assign o_m_tlast  = r_out_last;

    // No gate is handed out ahead of the samples seen.
    a_out_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_next_out <= r_gates))
        else $error("output gate counter ran past the gates received");

    // The divider only finishes while the sequencer waits for it.
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    // Closing a ray leaves the gate counters cleared.
    a_ray_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && (n_state == S_IDLE) && r_last) |=>
        ((r_gates == '0) && (r_next_out == '0)))
        else $error("ray counters not cleared at the end of a ray");

    // A new request is never taken while a slope still waits to be handed out.
    a_fit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !r_has_fit)
        else $error("request taken with a slope still pending");
endmodule
`default_nettype wire
